// ===== src/salc_pkg.sv =====
// Shared types and constants for the set-associative write-back cache core.
// No dependencies; used by the core.
package salc_pkg;

  localparam int MAX_WAYS    = 4;
  localparam int NUM_SETS    = 2;
  localparam int TAG_W       = 28;
  localparam int WAY_IDX_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W   = $clog2(MAX_WAYS + 8);
  localparam int SET_IDX_W   = $clog2(NUM_SETS);
  localparam int WAYS_RESET  = 2;
  localparam int PENALTY_RST = 30;

  typedef enum logic {
    CFG_WAYS_IN_USE  = 1'b0,
    CFG_MISS_PENALTY = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [31:0]      stamp;
    logic [31:0]      word_hi;
    logic [31:0]      word_lo;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// ===== src/salc_if.sv =====
// Handshake channels for cache requests and cache responses.
// Does not depend on salc_pkg; the field widths match those of the core.
interface salc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] fill_word_lo;
  logic [31:0] fill_word_hi;
  modport source (output valid, opcode, address, write_data, fill_word_lo, fill_word_hi,
                  input ready);
  modport sink (input valid, opcode, address, write_data, fill_word_lo, fill_word_hi,
                output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        hit;
  logic [7:0]  stall_cycles;
  logic        writeback_valid;
  logic [31:0] writeback_address;
  logic [31:0] writeback_word_lo;
  logic [31:0] writeback_word_hi;
  modport source (output valid, read_data, hit, stall_cycles, writeback_valid,
                  writeback_address, writeback_word_lo, writeback_word_hi, input ready);
  modport sink (input valid, read_data, hit, stall_cycles, writeback_valid,
                writeback_address, writeback_word_lo, writeback_word_hi, output ready);
endinterface

// ===== src/salc_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/set_assoc_writeback_lru_cache_core.sv =====
// Two-set write-back, write-allocate LRU cache core.
// Channels: in_req carries an access (opcode, address, write data and the two
// fill words of the addressed block); out_rsp returns one response per access
// with the read word, hit flag, stall cycles and an optional write-back of a
// dirty victim block. Both are valid/ready channels; a transfer happens when
// valid and ready are high at a rising edge of clk.
// Each set is one row of a synchronous RAM holding all ways. The row is read
// at the input transfer, updated and written back in the following cycle, and
// the response is registered at the end of that cycle. The next access is
// taken in the cycle the response is transferred, so a new access is not taken
// before the response of the previous one is transferred.
// While out_rsp is stalled the response register holds and in_req is not
// ready. The user writes configuration (cfg_we, cfg_index, cfg_wdata) only while idle;
// the core does not enforce it. Synchronous reset rst_n clears the row valid flags,
// the access timer, the control state and the configuration (two ways, penalty
// of 30); no clearing pass is needed.
// Depends on salc_pkg, salc_if and salc_ram.
module set_assoc_writeback_lru_cache_core
  import salc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  salc_req_if.sink         in_req,
  salc_rsp_if.source       out_rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata
);

  state_t state_r, state_nxt;
  logic [2:0]  ways_r;
  logic [7:0]  penalty_r;
  logic [31:0] timer_r;
  logic [NUM_SETS-1:0] row_valid_r;

  logic        op_r;
  logic [31:0] addr_r, wdata_r, fill_lo_r, fill_hi_r;

  logic [31:0] rd_data_r, wb_addr_r, wb_lo_r, wb_hi_r;
  logic        hit_r, wb_valid_r;
  logic [7:0]  stall_r;

  logic in_xfer, ram_we;
  logic [SET_IDX_W-1:0] ram_addr;
  row_t ram_rdata, row_cur, row_new;

  assign in_xfer  = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt    = state_r;
    in_req.ready = 1'b0;
    ram_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ram_we    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        in_req.ready = out_rsp.ready;
        if (out_rsp.ready) begin
          state_nxt = in_req.valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ram_addr = (state_r == ST_LOOKUP) ? addr_r[3] : in_req.address[3];

  salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (row_new),
    .rdata (ram_rdata)
  );

  assign row_cur = row_valid_r[addr_r[3]] ? ram_rdata : '0;

  logic [WAY_CNT_W-1:0] n_ways;
  logic [TAG_W-1:0]     tag;
  logic                 found, have_free;
  logic [WAY_IDX_W-1:0] hit_idx, free_idx, lru_idx, slot;
  logic [31:0]          stamp_new, rd_word;
  way_t                 victim, way_new;

  assign tag       = addr_r[31:4];
  assign stamp_new = timer_r + 32'd1;

  always_comb begin
    if (ways_r == 3'd0) begin
      n_ways = WAY_CNT_W'(1);
    end else if (WAY_CNT_W'(ways_r) > WAY_CNT_W'(MAX_WAYS)) begin
      n_ways = WAY_CNT_W'(MAX_WAYS);
    end else begin
      n_ways = WAY_CNT_W'(ways_r);
    end
  end

  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WAY_CNT_W'(j) < n_ways) begin
        if (!found && row_cur[j].valid && row_cur[j].tag == tag) begin
          found   = 1'b1;
          hit_idx = WAY_IDX_W'(j);
        end
        if (!have_free && !row_cur[j].valid) begin
          have_free = 1'b1;
          free_idx  = WAY_IDX_W'(j);
        end
        if (row_cur[j].stamp < row_cur[lru_idx].stamp) begin
          lru_idx = WAY_IDX_W'(j);
        end
      end
    end
  end

  always_comb begin
    slot    = found ? hit_idx : (have_free ? free_idx : lru_idx);
    victim  = row_cur[lru_idx];
    way_new = row_cur[slot];
    if (!found) begin
      way_new.word_lo = fill_lo_r;
      way_new.word_hi = fill_hi_r;
      way_new.tag     = tag;
      way_new.dirty   = 1'b0;
    end
    rd_word = addr_r[2] ? way_new.word_hi : way_new.word_lo;
    if (op_r) begin
      if (addr_r[2]) begin
        way_new.word_hi = wdata_r;
      end else begin
        way_new.word_lo = wdata_r;
      end
      way_new.dirty = 1'b1;
    end
    way_new.valid = 1'b1;
    way_new.stamp = stamp_new;
    row_new       = row_cur;
    row_new[slot] = way_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r      <= 3'(WAYS_RESET);
      penalty_r   <= 8'(PENALTY_RST);
      timer_r     <= '0;
      row_valid_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WAYS_IN_USE:  ways_r    <= cfg_wdata[2:0];
          CFG_MISS_PENALTY: penalty_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ram_we) begin
        timer_r               <= stamp_new;
        row_valid_r[addr_r[3]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_req.opcode;
      addr_r    <= in_req.address;
      wdata_r   <= in_req.write_data;
      fill_lo_r <= in_req.fill_word_lo;
      fill_hi_r <= in_req.fill_word_hi;
    end
    if (ram_we) begin
      rd_data_r  <= op_r ? 32'd0 : rd_word;
      hit_r      <= found;
      stall_r    <= found ? 8'd0 : penalty_r;
      wb_valid_r <= !found && !have_free && victim.dirty;
      if (!found && !have_free && victim.dirty) begin
        wb_addr_r <= {victim.tag, addr_r[3], 3'b000};
        wb_lo_r   <= victim.word_lo;
        wb_hi_r   <= victim.word_hi;
      end else begin
        wb_addr_r <= '0;
        wb_lo_r   <= '0;
        wb_hi_r   <= '0;
      end
    end
  end

  assign out_rsp.valid             = (state_r == ST_OUT);
  assign out_rsp.read_data         = rd_data_r;
  assign out_rsp.hit               = hit_r;
  assign out_rsp.stall_cycles      = stall_r;
  assign out_rsp.writeback_valid   = wb_valid_r;
  assign out_rsp.writeback_address = wb_addr_r;
  assign out_rsp.writeback_word_lo = wb_lo_r;
  assign out_rsp.writeback_word_hi = wb_hi_r;

  a_hit_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.hit |-> out_rsp.stall_cycles == 8'd0)
    else $error("hit response reports stall cycles");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.hit |-> !out_rsp.writeback_valid)
    else $error("hit response carries a write-back");

  a_lookup_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_LOOKUP)
    else $error("accepted access not looked up");

  a_timer_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |=> timer_r == $past(timer_r) + 32'd1)
    else $error("access timer did not advance");

endmodule
